// ----- rtl/core/csrspmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types, constants and codes of the complex CSR row multiplier.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

	localparam int VEC_DEPTH   = 4096;
	localparam int VEC_AW      = $clog2(VEC_DEPTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_NZ    = 2'd1;
	localparam logic [1:0] KIND_LAST  = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [1:0] REG_SCALE_RE     = 2'd0;
	localparam logic [1:0] REG_SCALE_IM     = 2'd1;
	localparam logic [1:0] REG_UNIT_WEIGHTS = 2'd2;

	localparam logic signed [31:0] ONE_Q824   = 32'sh0100_0000;
	localparam logic signed [31:0] SAT_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN    = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_MAC      = 2'd1,
		OP_MAC_EMIT = 2'd2,
		OP_EMIT     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        index;
		logic signed [31:0] part_re;
		logic signed [31:0] part_im;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] y_re;
		logic signed [31:0] y_im;
		logic [15:0]        row_number;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic [VEC_AW-1:0]  addr;
		logic               in_range;
		logic signed [31:0] val_re;
		logic signed [31:0] val_im;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic signed [31:0] scale_re;
		logic signed [31:0] scale_im;
	} scale_t;

endpackage

// ----- rtl/core/csrspmv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_front
// Accepts input beats, decodes the kind into an operation and applies unit
// weighting, then hands the work to the queue.
// ----------------------------------------------------------------------------
module csrspmv_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  csrspmv_pkg::in_item_t in_data,
	input  logic                  unit_weights,
	input  csrspmv_pkg::q_status_t q_stat,
	output logic                  push,
	output csrspmv_pkg::work_t    push_item
);
	import csrspmv_pkg::*;

	logic  valid_s1;
	work_t item_s1;
	work_t item_d;

	always_comb begin
		item_d.addr     = VEC_AW'(in_data.index);
		item_d.in_range = (32'(in_data.index) < 32'(VEC_DEPTH));
		item_d.val_re   = in_data.part_re;
		item_d.val_im   = in_data.part_im;
		unique case (in_data.kind)
			KIND_LOAD: begin
				item_d.op = OP_LOAD;
			end
			KIND_NZ: begin
				item_d.op = OP_MAC;
			end
			KIND_LAST: begin
				item_d.op = OP_MAC_EMIT;
			end
			KIND_EMPTY: begin
				item_d.op = OP_EMIT;
			end
		endcase
		if (unit_weights && (in_data.kind == KIND_NZ || in_data.kind == KIND_LAST)) begin
			item_d.val_re = ONE_Q824;
			item_d.val_im = '0;
		end
	end

	assign push      = valid_s1 && !q_stat.full;
	assign push_item = item_s1;
	assign in_ready  = !valid_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- rtl/core/csrspmv_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_queue
// Short FIFO of decoded work between the front end and the datapath.
// ----------------------------------------------------------------------------
module csrspmv_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  csrspmv_pkg::work_t     push_item,
	input  logic                   pop,
	output csrspmv_pkg::work_t     head,
	output csrspmv_pkg::q_status_t q_stat
);
	import csrspmv_pkg::*;

	work_t               entries [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
		logic [QUEUE_AW-1:0] r;
		if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QUEUE_AW'(1);
		end
		return r;
	endfunction

	assign q_stat.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/core/csrspmv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_back
// Vector store, complex multiply-accumulate pipeline, output scaling with
// saturation, and the output register.
// ----------------------------------------------------------------------------
module csrspmv_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csrspmv_pkg::scale_t    scale,
	input  csrspmv_pkg::work_t     head,
	input  csrspmv_pkg::q_status_t q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output csrspmv_pkg::out_item_t out_data
);
	import csrspmv_pkg::*;

	logic [63:0] vec_mem [VEC_DEPTH];

	logic advance;

	logic               v_s1, mac_s1, emit_s1, rng_s1;
	logic signed [31:0] a_s1, b_s1;
	logic [63:0]        rd_s1;

	logic               v_s2, mac_s2, emit_s2;
	logic signed [63:0] p_ac_s2, p_bd_s2, p_ad_s2, p_bc_s2;

	logic               v_s3, mac_s3, emit_s3;
	logic signed [47:0] dre_s3, dim_s3;

	logic signed [47:0] acc_re_q, acc_im_q;

	logic               v_s4;
	logic signed [47:0] ar_s4, ai_s4;

	logic               v_s5;
	logic signed [56:0] m_rrh_s5, m_rrl_s5, m_iih_s5, m_iil_s5;
	logic signed [56:0] m_rih_s5, m_ril_s5, m_irh_s5, m_irl_s5;

	logic               v_s6;
	logic signed [57:0] yre_s6, yim_s6;

	logic               out_valid_q;
	out_item_t          out_q;
	logic [15:0]        row_q;

	logic signed [31:0] c_d, d_d;
	logic signed [64:0] sum_re, sum_im;
	logic signed [47:0] acc_re_sum, acc_im_sum;
	logic signed [23:0] ar_hi, ai_hi;
	logic signed [24:0] ar_lo, ai_lo;
	logic signed [57:0] hre, lre, him, lim;
	logic               clip_re, clip_im;
	logic signed [31:0] yre_sat, yim_sat;

	assign advance   = !(out_valid_q && !out_ready && v_s6);
	assign pop       = advance && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.op == OP_LOAD && head.in_range) begin
				vec_mem[head.addr] <= {head.val_im, head.val_re};
			end
			rd_s1 <= vec_mem[head.addr];
		end
	end

	always_comb begin
		c_d        = rng_s1 ? signed'(rd_s1[31:0])  : 32'sd0;
		d_d        = rng_s1 ? signed'(rd_s1[63:32]) : 32'sd0;
		sum_re     = 65'(p_ac_s2) - 65'(p_bd_s2);
		sum_im     = 65'(p_ad_s2) + 65'(p_bc_s2);
		acc_re_sum = acc_re_q + (mac_s3 ? dre_s3 : 48'sd0);
		acc_im_sum = acc_im_q + (mac_s3 ? dim_s3 : 48'sd0);
		ar_hi      = ar_s4[47:24];
		ai_hi      = ai_s4[47:24];
		ar_lo      = signed'({1'b0, ar_s4[23:0]});
		ai_lo      = signed'({1'b0, ai_s4[23:0]});
		hre        = 58'(m_rrh_s5) - 58'(m_iih_s5);
		lre        = 58'(m_rrl_s5) - 58'(m_iil_s5);
		him        = 58'(m_rih_s5) + 58'(m_irh_s5);
		lim        = 58'(m_ril_s5) + 58'(m_irl_s5);
		clip_re    = !((&yre_s6[57:31]) || !(|yre_s6[57:31]));
		clip_im    = !((&yim_s6[57:31]) || !(|yim_s6[57:31]));
		yre_sat    = clip_re ? (yre_s6[57] ? SAT_MIN : SAT_MAX) : yre_s6[31:0];
		yim_sat    = clip_im ? (yim_s6[57] ? SAT_MIN : SAT_MAX) : yim_s6[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
		end else begin
			if (advance) begin
				v_s1 <= pop && head.op != OP_LOAD;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3 && emit_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				if (v_s3) begin
					if (emit_s3) begin
						acc_re_q <= '0;
						acc_im_q <= '0;
					end else begin
						acc_re_q <= acc_re_sum;
						acc_im_q <= acc_im_sum;
					end
				end
			end
			if (advance && v_s6) begin
				out_valid_q <= 1'b1;
				row_q       <= row_q + 16'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mac_s1  <= head.op == OP_MAC || head.op == OP_MAC_EMIT;
			emit_s1 <= head.op == OP_EMIT || head.op == OP_MAC_EMIT;
			rng_s1  <= head.in_range;
			a_s1    <= head.val_re;
			b_s1    <= head.val_im;

			mac_s2  <= mac_s1;
			emit_s2 <= emit_s1;
			p_ac_s2 <= a_s1 * c_d;
			p_bd_s2 <= b_s1 * d_d;
			p_ad_s2 <= a_s1 * d_d;
			p_bc_s2 <= b_s1 * c_d;

			mac_s3  <= mac_s2;
			emit_s3 <= emit_s2;
			dre_s3  <= 48'(sum_re >>> 24);
			dim_s3  <= 48'(sum_im >>> 24);

			ar_s4 <= acc_re_sum;
			ai_s4 <= acc_im_sum;

			m_rrh_s5 <= scale.scale_re * ar_hi;
			m_rrl_s5 <= scale.scale_re * ar_lo;
			m_iih_s5 <= scale.scale_im * ai_hi;
			m_iil_s5 <= scale.scale_im * ai_lo;
			m_rih_s5 <= scale.scale_re * ai_hi;
			m_ril_s5 <= scale.scale_re * ai_lo;
			m_irh_s5 <= scale.scale_im * ar_hi;
			m_irl_s5 <= scale.scale_im * ar_lo;

			yre_s6 <= hre + (lre >>> 24);
			yim_s6 <= him + (lim >>> 24);
		end
		if (advance && v_s6) begin
			out_q.y_re       <= yre_sat;
			out_q.y_im       <= yim_sat;
			out_q.row_number <= row_q;
			out_q.saturated  <= clip_re || clip_im;
		end
	end

endmodule

// ----- rtl/core/complex_csr_spmv_row.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_csr_spmv_row
// Complex sparse matrix-vector multiply over CSR rows in Q8.24.
// ----------------------------------------------------------------------------
// Input beats carry a kind, an index and a complex value. Load beats write one
// vector element into the internal store, nonzero beats multiply the value by
// the stored element and add it to a 48-bit complex accumulator, and last or
// empty-row beats close the row. A closed row is scaled by the complex
// scale register, saturated, and sent as one output beat with its row number.
// A front register decodes each beat into a four-entry queue. Unless the
// output stalls as below, the datapath drains one beat per cycle from the
// queue through the store read, the complex multipliers, the accumulator and
// the two scaling stages, and sustains one input beat per cycle, set by the
// single store port and the single accumulator update per cycle. A closing
// beat passes the front register, queue, stages s1-s6 and output register.
// When the output receiver stalls with a result still waiting and another
// one finished, the datapath holds; the queue then fills and in_ready drops.
// Reset clears the accumulator, the row number and the scale registers to
// 1.0 and 0; the vector store is not cleared and must be loaded before use.
// The configuration port is always ready and should be written only while
// no rows are in flight.
// ----------------------------------------------------------------------------
module complex_csr_spmv_row (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  csrspmv_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output csrspmv_pkg::out_item_t out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data
);
	import csrspmv_pkg::*;

	scale_t    scale_q;
	logic      unit_q;
	logic      push;
	work_t     push_item;
	logic      pop;
	work_t     head;
	q_status_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q.scale_re <= ONE_Q824;
			scale_q.scale_im <= '0;
			unit_q           <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCALE_RE: begin
					scale_q.scale_re <= cfg_data;
				end
				REG_SCALE_IM: begin
					scale_q.scale_im <= cfg_data;
				end
				REG_UNIT_WEIGHTS: begin
					unit_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	csrspmv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.unit_weights (unit_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_item    (push_item)
	);

	csrspmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	csrspmv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (scale_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_row_number_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid
			|| out_data.row_number == 16'($past(out_data.row_number) + 16'd1))
		else $error("row number did not advance by one between output beats");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.y_re == SAT_MAX
			|| out_data.y_re == SAT_MIN || out_data.y_im == SAT_MAX
			|| out_data.y_im == SAT_MIN)
		else $error("saturation flag set without a clipped result part");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> !push || q_stat.full)
		else $error("queue full flag dropped without a pop");

endmodule
